// ===== hw/rtl/partitioned_clock_cool_replacement_macros.svh =====
// Assertion macros used by the back end of the replacement engine.
`ifndef PARTITIONED_CLOCK_COOL_REPLACEMENT_MACROS_SVH
`define PARTITIONED_CLOCK_COOL_REPLACEMENT_MACROS_SVH
`ifndef SYNTHESIS
`define PCCR_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define PCCR_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define PCCR_ASSERT_IMP(lbl, a, b)
`define PCCR_ASSERT_NXT(lbl, a, b)
`endif
`endif

// ===== hw/rtl/pccr_pkg.sv =====
// Types and constants of the partitioned clock replacement engine.
package pccr_pkg;
	localparam int NUM_BUFFERS = 1024;
	localparam int MAX_PARTITIONS = 16;
	localparam int IDX_W = $clog2(NUM_BUFFERS);
	localparam int SIZE_W = IDX_W + 1;
	localparam int PART_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int LG_W = 3;
	localparam int ID_W = 24;
	localparam int PIN_W = 16;
	localparam int CNT_W = 32;

	typedef enum logic [2:0] {
		CMD_HIT    = 3'd0,
		CMD_MISS   = 3'd1,
		CMD_LOAD   = 3'd2,
		CMD_VICTIM = 3'd3,
		CMD_PIN    = 3'd4,
		CMD_UNPIN  = 3'd5,
		CMD_DROP   = 3'd6,
		CMD_NONE   = 3'd7
	} cmd_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NOVICTIM = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	localparam logic CFG_POOL_SIZE = 1'b0;
	localparam logic CFG_FIRST_ID = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] n;
		logic [LG_W-1:0]   lg;
		logic [ID_W-1:0]   first_id;
	} cfg_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              in_range;
		logic [IDX_W-1:0]  idx;
		logic              vac;
		logic [PART_W-1:0] start;
	} word_t;

	typedef struct packed {
		logic  avail;
		word_t word;
	} fq_t;

	typedef struct packed {
		logic deq;
		logic clearing;
	} bk_t;
endpackage

// ===== hw/rtl/pccr_front.sv =====
// Front end: classifies incoming words and holds them in a two-entry queue.
module pccr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pccr_pkg::cfg_t       cfg,
	input  logic                 push,
	output logic                 full,
	input  logic [2:0]           cmd,
	input  logic [23:0]          buffer_id,
	input  logic                 vacuum_load,
	input  logic [15:0]          requester,
	input  pccr_pkg::bk_t        bk,
	output pccr_pkg::fq_t        fq
);
	pccr_pkg::word_t word_in;
	pccr_pkg::word_t slot_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	logic [23:0]     diff;
	logic [pccr_pkg::PART_W-1:0] pmask;
	logic            enq;

	assign diff = buffer_id - cfg.first_id;
	assign pmask = pccr_pkg::PART_W'((1 << cfg.lg) - 1);

	always_comb begin
		word_in.cmd = pccr_pkg::cmd_t'(cmd);
		word_in.in_range = (buffer_id >= cfg.first_id) &&
			(diff < 24'(cfg.n));
		word_in.idx = diff[pccr_pkg::IDX_W-1:0];
		word_in.vac = vacuum_load;
		word_in.start = requester[pccr_pkg::PART_W-1:0] & pmask;
	end

	// No word is taken while the back end clears its table.
	assign full = (cnt_q == 2'd2) || bk.clearing;
	assign enq = push && !full;
	assign fq.avail = (cnt_q != 2'd0);
	assign fq.word = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) slot_q[wr_ptr_q] <= word_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wr_ptr_q <= !wr_ptr_q;
			if (bk.deq) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(enq) - 2'(bk.deq);
		end
	end
endmodule

// ===== hw/rtl/pccr_back.sv =====
// Back end: entry table, clock hands, victim search and the result register.
`include "partitioned_clock_cool_replacement_macros.svh"
module pccr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pccr_pkg::cfg_t       cfg,
	input  pccr_pkg::fq_t        fq,
	output pccr_pkg::bk_t        bk,
	input  logic                 pop,
	output logic                 empty,
	output logic [1:0]           status,
	output logic [23:0]          victim_id,
	output logic                 victim_was_free,
	output logic [15:0]          pin_count_after,
	output logic [31:0]          inflight_count
);
	localparam int IW = pccr_pkg::IDX_W;
	localparam int SW = pccr_pkg::SIZE_W;
	localparam int PW = pccr_pkg::PART_W;

	typedef struct packed {
		logic                      cool;
		logic                      valid;
		logic [pccr_pkg::PIN_W-1:0] pin;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_UPD, S_P1_SET, S_P1_SCAN,
		S_P2_SET, S_P2_MOD, S_P2_RD, S_P2_ACT
	} state_t;

	state_t          state_q;
	pccr_pkg::word_t w_q;
	entry_t          mem [pccr_pkg::NUM_BUFFERS];
	entry_t          rdata_q, wdata, upd;
	logic            we;
	logic [IW-1:0]   waddr, raddr;
	logic [IW-1:0]   clr_q, p1_idx_q, raddr_s1;
	logic [SW-1:0]   p1_iss_q, p1_chk_q;
	logic            rvalid_s1;
	logic [IW-1:0]   hand_q [pccr_pkg::MAX_PARTITIONS];
	logic [IW-1:0]   h_q, first_q, hnext;
	logic [SW-1:0]   size_q;
	logic [SW:0]     j_q;
	logic [5:0]      k_q;
	logic [PW-1:0]   p_q, p_sel, pmask;
	logic [SW-1:0]   base, extra, psize;
	logic [IW-1:0]   pfirst;
	logic            p_low, ent_free, p1_hit;
	logic [1:0]      upd_st;
	logic            out_v_q, free_q;
	logic [1:0]      st_q;
	logic [23:0]     vid_q;
	logic [15:0]     pins_q;
	logic [31:0]     infl_q;

	assign pmask = PW'((1 << cfg.lg) - 1);
	assign p_sel = (w_q.start + k_q[PW-1:0]) & pmask;
	assign base = cfg.n >> cfg.lg;
	assign extra = cfg.n & SW'(pmask);
	assign p_low = SW'(p_sel) < extra;
	assign psize = base + SW'(p_low);
	assign pfirst = IW'(p_sel * base) + (p_low ? IW'(p_sel) : IW'(extra));

	assign ent_free = !rdata_q.valid && (rdata_q.pin == '0);
	assign p1_hit = rvalid_s1 && ent_free;
	assign hnext = (SW'(h_q) + SW'(1) == size_q) ? '0 : h_q + IW'(1);

	always_comb begin
		upd = rdata_q;
		upd_st = pccr_pkg::ST_OK;
		case (w_q.cmd)
			pccr_pkg::CMD_HIT: upd.cool = 1'b0;
			pccr_pkg::CMD_LOAD: begin
				upd.valid = 1'b1;
				upd.cool = w_q.vac;
			end
			pccr_pkg::CMD_PIN: begin
				if (rdata_q.pin == '1) upd_st = pccr_pkg::ST_SAT;
				else upd.pin = rdata_q.pin + 16'd1;
			end
			pccr_pkg::CMD_UNPIN: begin
				if (rdata_q.pin == '0) upd_st = pccr_pkg::ST_SAT;
				else upd.pin = rdata_q.pin - 16'd1;
			end
			pccr_pkg::CMD_DROP: upd.valid = 1'b0;
			default: upd = rdata_q;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = w_q.idx;
		wdata = upd;
		raddr = '0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_IDLE: raddr = fq.word.idx;
			S_UPD: we = 1'b1;
			S_P1_SCAN: begin
				raddr = p1_idx_q;
				we = p1_hit;
				waddr = raddr_s1;
				wdata = '{cool: rdata_q.cool, valid: 1'b0, pin: 16'd1};
			end
			S_P2_RD: raddr = first_q + h_q;
			S_P2_ACT: begin
				waddr = first_q + h_q;
				we = rdata_q.valid && (rdata_q.pin == '0);
				wdata = rdata_q.cool ? '{cool: 1'b1, valid: 1'b1, pin: 16'd1}
					: '{cool: 1'b1, valid: 1'b1, pin: rdata_q.pin};
			end
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign bk.clearing = (state_q == S_CLEAR);
	assign bk.deq = (state_q == S_IDLE) && fq.avail && !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			infl_q <= '0;
			rvalid_s1 <= 1'b0;
			for (int i = 0; i < pccr_pkg::MAX_PARTITIONS; i++) hand_q[i] <= '0;
		end else begin
			if (pop && out_v_q) out_v_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(pccr_pkg::NUM_BUFFERS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (bk.deq) begin
						w_q <= fq.word;
						st_q <= pccr_pkg::ST_OK;
						vid_q <= '0;
						free_q <= 1'b0;
						pins_q <= '0;
						case (fq.word.cmd)
							pccr_pkg::CMD_MISS: begin
								infl_q <= infl_q + 32'd1;
								out_v_q <= 1'b1;
							end
							pccr_pkg::CMD_NONE: out_v_q <= 1'b1;
							pccr_pkg::CMD_VICTIM: begin
								k_q <= '0;
								state_q <= S_P1_SET;
							end
							default: begin
								if (fq.word.in_range) state_q <= S_UPD;
								else begin
									st_q <= pccr_pkg::ST_RANGE;
									out_v_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_UPD: begin
					st_q <= upd_st;
					pins_q <= upd.pin;
					if (w_q.cmd == pccr_pkg::CMD_LOAD) infl_q <= infl_q - 32'd1;
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_P1_SET: begin
					// The first pass walks the whole pool from the start partition on.
					p1_idx_q <= pfirst;
					p1_iss_q <= '0;
					p1_chk_q <= '0;
					rvalid_s1 <= 1'b0;
					state_q <= S_P1_SCAN;
				end
				S_P1_SCAN: begin
					rvalid_s1 <= (p1_iss_q != cfg.n);
					raddr_s1 <= p1_idx_q;
					if (p1_iss_q != cfg.n) begin
						p1_iss_q <= p1_iss_q + SW'(1);
						p1_idx_q <= (SW'(p1_idx_q) + SW'(1) == cfg.n) ? '0
							: p1_idx_q + IW'(1);
					end
					if (p1_hit) begin
						vid_q <= cfg.first_id + 24'(raddr_s1);
						free_q <= 1'b1;
						pins_q <= 16'd1;
						out_v_q <= 1'b1;
						rvalid_s1 <= 1'b0;
						state_q <= S_IDLE;
					end else if (rvalid_s1) begin
						p1_chk_q <= p1_chk_q + SW'(1);
						if (p1_chk_q + SW'(1) == cfg.n) begin
							rvalid_s1 <= 1'b0;
							state_q <= S_P2_SET;
						end
					end
				end
				S_P2_SET: begin
					p_q <= p_sel;
					first_q <= pfirst;
					size_q <= psize;
					h_q <= hand_q[p_sel];
					j_q <= '0;
					state_q <= S_P2_MOD;
				end
				S_P2_MOD: begin
					// A hand left past its partition by a new split is reduced here.
					if (SW'(h_q) >= size_q) h_q <= h_q - IW'(size_q);
					else state_q <= S_P2_RD;
				end
				S_P2_RD: state_q <= S_P2_ACT;
				S_P2_ACT: begin
					hand_q[p_q] <= hnext;
					h_q <= hnext;
					j_q <= j_q + (SW+1)'(1);
					if (rdata_q.valid && rdata_q.pin == '0 && rdata_q.cool) begin
						vid_q <= cfg.first_id + 24'(first_q + h_q);
						pins_q <= 16'd1;
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (j_q + (SW+1)'(1) == {size_q, 1'b0}) begin
						if (k_q + 6'd1 == 6'(3 << cfg.lg)) begin
							st_q <= pccr_pkg::ST_NOVICTIM;
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 6'd1;
							state_q <= S_P2_SET;
						end
					end else begin
						state_q <= S_P2_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign empty = !out_v_q;
	assign status = st_q;
	assign victim_id = vid_q;
	assign victim_was_free = free_q;
	assign pin_count_after = pins_q;
	assign inflight_count = infl_q;

	`PCCR_ASSERT_IMP(a_no_take_clear, state_q == S_CLEAR, !bk.deq)
	`PCCR_ASSERT_IMP(a_hand_in_part, state_q == S_P2_ACT, SW'(h_q) < size_q)
	`PCCR_ASSERT_IMP(a_scan_write_free, state_q == S_P1_SCAN && we, p1_hit)
	`PCCR_ASSERT_NXT(a_take_sets_busy, bk.deq, out_v_q || state_q != S_IDLE)
endmodule

// ===== hw/rtl/partitioned_clock_cool_replacement.sv =====
// Top level of the partitioned clock replacement engine with cool flags.
//
//  channel  | handshake          | ports
//  ---------+--------------------+------------------------------------------------
//  input    | push / full        | cmd buffer_id vacuum_load requester
//  result   | pop / empty        | status victim_id victim_was_free pin_count_after
//           |                    | inflight_count
//  config   | cfg_we             | cfg_index cfg_wdata
//
// Hit, load, pin, unpin and drop take a table read, then a write, in the back end;
// miss and out-of-range words need no table access. A victim request first scans
// the pool for a free entry and, if none is found, sweeps the entries, reading each
// one and then acting on it. After reset the back end clears its 1024-entry table;
// full is high until then. Each word's result waits in a single result register,
// and the back end takes no new word until it is popped; the two-entry front queue
// keeps accepting meanwhile.
module partitioned_clock_cool_replacement (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [23:0] buffer_id,
	input  logic        vacuum_load,
	input  logic [15:0] requester,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  status,
	output logic [23:0] victim_id,
	output logic        victim_was_free,
	output logic [15:0] pin_count_after,
	output logic [31:0] inflight_count,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_wdata
);
	logic [10:0]    pool_size_q;
	logic [23:0]    first_id_q;
	pccr_pkg::cfg_t cfg;
	pccr_pkg::fq_t  fq;
	pccr_pkg::bk_t  bk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= 11'd1024;
			first_id_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == pccr_pkg::CFG_POOL_SIZE) pool_size_q <= cfg_wdata[10:0];
			else first_id_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (pool_size_q == '0) cfg.n = pccr_pkg::SIZE_W'(1);
		else if (32'(pool_size_q) > pccr_pkg::NUM_BUFFERS)
			cfg.n = pccr_pkg::SIZE_W'(pccr_pkg::NUM_BUFFERS);
		else cfg.n = pccr_pkg::SIZE_W'(pool_size_q);
		if (32'(cfg.n) < 256) cfg.lg = 3'd0;
		else if (32'(cfg.n) < 1024) cfg.lg = 3'd1;
		else if (32'(cfg.n) < 4096) cfg.lg = 3'd2;
		else if (32'(cfg.n) < 16384) cfg.lg = 3'd3;
		else cfg.lg = 3'd4;
		if (32'(cfg.lg) > $clog2(pccr_pkg::MAX_PARTITIONS))
			cfg.lg = 3'($clog2(pccr_pkg::MAX_PARTITIONS));
		cfg.first_id = first_id_q;
	end

	pccr_front u_front (
		.clk, .arst_n, .cfg, .push, .full, .cmd, .buffer_id, .vacuum_load,
		.requester, .bk, .fq
	);

	pccr_back u_back (
		.clk, .arst_n, .cfg, .fq, .bk, .pop, .empty, .status, .victim_id,
		.victim_was_free, .pin_count_after, .inflight_count
	);
endmodule
